// ----- rtl/core/fabrik_chain_solver_core_assert.svh -----
// assertion macros shared by the fabrik chain solver rtl
// used inside modules that have clk and rst_n; no other dependencies
`ifndef FABRIK_CHAIN_SOLVER_CORE_ASSERT_SVH
`define FABRIK_CHAIN_SOLVER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcs assertion failed");
`define FCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcs assertion failed");
`else
`define FCS_ASSERT_SAME(label, ante, cons)
`define FCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/fcs_pkg.sv -----
// package for the fabrik chain solver: sizes, payload structs, codes
// and the controller/datapath command interface; no dependencies
package fcs_pkg;

    localparam int MAX_JOINTS = 16;
    localparam int COORD_BITS = 24;
    localparam int IDXW       = $clog2(MAX_JOINTS);
    localparam int CNTW       = $clog2(MAX_JOINTS + 1);
    localparam int CFGW       = 23;
    localparam int RW         = COORD_BITS + 2;       // root / link length
    localparam int SQW        = 2 * RW;               // sum of squares
    localparam int UFRAC      = 30;                   // unit vector fraction bits
    localparam int UW         = UFRAC + 1;            // unit component magnitude
    localparam int PW         = RW + UW;              // multiplier product
    localparam int OFW        = PW - UFRAC;           // offset magnitude
    localparam int SUMW       = OFW + 2;              // coordinate plus offset
    localparam int NUMW       = RW + UFRAC;           // divider numerator
    localparam int DCNTW      = $clog2(UW + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_MOVE   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_REJECT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        CFG_ARENA   = 1'b0,
        CFG_CAPTURE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
    } item_t;

    typedef struct packed {
        logic [3:0]         joint_index;
        logic signed [23:0] joint_x;
        logic signed [23:0] joint_y;
        status_t            status;
        logic               last_of_run;
    } result_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD_IN,
        DP_CLEAR,
        DP_APPEND,
        DP_EMIT_ZERO,
        DP_ARENA_SQ,
        DP_A_JOINT,
        DP_A_NEW,
        DP_B_JOINT,
        DP_B_NEW,
        DP_B_TGT,
        DP_AR_LD,
        DP_SQX,
        DP_SQY,
        DP_SUM,
        DP_ROOT_GO,
        DP_DIV_GO,
        DP_UNIT,
        DP_LEN_STORE,
        DP_LEN_LOAD,
        DP_LEN_CAP,
        DP_OFFX,
        DP_OFFY,
        DP_OFFEND,
        DP_TGT_FIX,
        DP_NEW_FROM_P,
        DP_NEW_FROM_J,
        DP_NEW_WRITE,
        DP_BAD_CLR,
        DP_AR_CHK,
        DP_COMMIT_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [IDXW-1:0] addr;
        status_t         st;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic [CNTW-1:0] count;
        logic            root_done;
        logic            div_done;
    } sts_t;

    typedef enum logic [2:0] {
        PH_TGT,
        PH_LEN,
        PH_BWD,
        PH_FWD,
        PH_ARENA
    } phase_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_CLEAR,
        S_APPEND,
        S_SHORT,
        S_ARSQ,
        S_T_A,
        S_T_B,
        S_M_SQX,
        S_M_SQY,
        S_M_SUM,
        S_M_RGO,
        S_M_RWAIT,
        S_M_DGO,
        S_M_DWAIT,
        S_M_UNIT,
        S_T_LEN,
        S_O_X,
        S_O_Y,
        S_O_END,
        S_T_FIX,
        S_L_A,
        S_L_B,
        S_L_ST,
        S_B_INIT,
        S_B_A,
        S_B_B,
        S_B_LEN,
        S_B_WR,
        S_F_INIT,
        S_F_A,
        S_F_B,
        S_F_LEN,
        S_F_WR,
        S_R_CLR,
        S_R_LD,
        S_R_CHK,
        S_EMIT
    } state_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        hi = SUMW'({1'b0, {(COORD_BITS-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            return hi[COORD_BITS-1:0];
        else if (v < lo)
            return lo[COORD_BITS-1:0];
        else
            return v[COORD_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/fcs_sqrt.sv -----
// iterative rounded square root, digit by digit; a go restarts it
// depends on fcs_pkg
module fcs_sqrt import fcs_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [SQW-1:0] value,
    output logic          done,
    output logic [RW-1:0] root
);

    logic [SQW-1:0] v_reg,   v_next;
    logic [SQW:0]   r_reg,   r_next;
    logic [SQW-1:0] bit_reg, bit_next;
    logic [RW-1:0]  root_reg, root_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;
    logic [SQW:0]   trial;

    assign trial = r_reg + (SQW+1)'(bit_reg);

    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            v_next   = value;
            r_next   = '0;
            bit_next = SQW'(1) << (SQW - 2);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (bit_reg != '0)
            begin
                if ((SQW+1)'(v_reg) >= trial)
                begin
                    v_next = v_reg - SQW'(trial);
                    r_next = (r_reg >> 1) + (SQW+1)'(bit_reg);
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                // round to nearest
                root_next = ((SQW+1)'(v_reg) > r_reg) ? RW'(r_reg + 1'b1) : RW'(r_reg);
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/core/fcs_div.sv -----
// restoring divider, one quotient bit per step
// depends on fcs_pkg
module fcs_div import fcs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  logic [NUMW-1:0] num,
    input  logic [RW-1:0]   den,
    output logic            done,
    output logic [UW-1:0]   quo
);

    logic [RW-1:0]    rem_reg, rem_next;
    logic [UW-1:0]    nq_reg,  nq_next;
    logic [DCNTW-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [RW:0]      shifted;
    logic             fits;

    assign shifted = {rem_reg, nq_reg[UW-1]};
    assign fits    = shifted >= (RW+1)'(den);

    always_comb
    begin
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            // upper part is below den whenever the quotient fits
            rem_next = RW'(num[NUMW-1:UW]);
            nq_next  = num[UW-1:0];
            cnt_next = DCNTW'(UW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = fits ? RW'(shifted - (RW+1)'(den)) : RW'(shifted);
                nq_next  = {nq_reg[UW-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

// ----- rtl/core/fcs_datapath.sv -----
// datapath of the fabrik chain solver: chain storage, shared multiplier,
// root and divider units, result register; depends on fcs_pkg, fcs_sqrt, fcs_div
`include "fabrik_chain_solver_core_assert.svh"
module fcs_datapath import fcs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  item_t           item,
    input  cmd_t            cmd,
    input  logic            cfg_we,
    input  cfg_idx_t        cfg_index,
    input  logic [CFGW-1:0] cfg_data,
    output sts_t            sts,
    output logic            result_valid,
    output result_t         result
);

    logic signed [COORD_BITS-1:0] jx_mem [MAX_JOINTS];
    logic signed [COORD_BITS-1:0] jy_mem [MAX_JOINTS];
    logic signed [COORD_BITS-1:0] nx_mem [MAX_JOINTS];
    logic signed [COORD_BITS-1:0] ny_mem [MAX_JOINTS];
    logic [RW-1:0]                len_mem [MAX_JOINTS];

    logic [CNTW-1:0]              count_reg;
    logic [CFGW-1:0]              arena_reg;
    logic [CFGW-1:0]              cap_reg;
    logic                         bad_reg;
    logic                         valid_reg;
    result_t                      res_reg;

    logic signed [COORD_BITS-1:0] px_reg, py_reg, bx_reg, by_reg;
    logic [RW-2:0]                mx_reg, my_reg;
    logic                         sgx_reg, sgy_reg;
    logic [PW-1:0]                prod_reg;
    logic [SQW-1:0]               sum_reg, ar2_reg;
    logic [RW-1:0]                len_reg;
    logic [UW-1:0]                umx_reg, umy_reg;
    logic signed [OFW:0]          offx_reg, offy_reg;
    logic                         far_reg;

    logic signed [COORD_BITS-1:0] jx_rd, jy_rd, nx_rd, ny_rd;
    logic [RW-1:0]                len_rd;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [RW-2:0]                ax_c, ay_c;
    logic [RW-1:0]                mul_a;
    logic [UW-1:0]                mul_b;
    logic [PW-1:0]                mul_p;
    logic [PW-1:0]                rnd;
    logic [OFW-1:0]               off_mag;
    logic signed [OFW:0]          off_c;
    logic                         off_neg;
    logic signed [COORD_BITS-1:0] newx, newy;
    logic [RW-1:0]                root;
    logic                         root_done;
    logic [UW-1:0]                quox, quoy;
    logic                         dvx_done, dvy_done;
    logic [NUMW-1:0]              numx, numy;

    assign jx_rd  = jx_mem[cmd.addr];
    assign jy_rd  = jy_mem[cmd.addr];
    assign nx_rd  = nx_mem[cmd.addr];
    assign ny_rd  = ny_mem[cmd.addr];
    assign len_rd = len_mem[cmd.addr];

    // difference vector for the measure step; the arena check takes the new point itself
    always_comb
    begin
        unique case (cmd.op)
            DP_B_NEW:
            begin
                dx = (COORD_BITS+1)'(nx_rd) - (COORD_BITS+1)'(bx_reg);
                dy = (COORD_BITS+1)'(ny_rd) - (COORD_BITS+1)'(by_reg);
            end
            DP_B_TGT:
            begin
                dx = (COORD_BITS+1)'(px_reg) - (COORD_BITS+1)'(bx_reg);
                dy = (COORD_BITS+1)'(py_reg) - (COORD_BITS+1)'(by_reg);
            end
            DP_AR_LD:
            begin
                dx = (COORD_BITS+1)'(nx_rd);
                dy = (COORD_BITS+1)'(ny_rd);
            end
            default:
            begin
                dx = (COORD_BITS+1)'(jx_rd) - (COORD_BITS+1)'(bx_reg);
                dy = (COORD_BITS+1)'(jy_rd) - (COORD_BITS+1)'(by_reg);
            end
        endcase
    end

    assign ax_c = dx[COORD_BITS] ? (RW-1)'(-dx) : (RW-1)'(dx);
    assign ay_c = dy[COORD_BITS] ? (RW-1)'(-dy) : (RW-1)'(dy);

    always_comb
    begin
        unique case (cmd.op)
            DP_SQX:
            begin
                mul_a = RW'(mx_reg);
                mul_b = UW'(mx_reg);
            end
            DP_SQY:
            begin
                mul_a = RW'(my_reg);
                mul_b = UW'(my_reg);
            end
            DP_ARENA_SQ:
            begin
                mul_a = RW'(arena_reg);
                mul_b = UW'(arena_reg);
            end
            DP_OFFX:
            begin
                mul_a = len_reg;
                mul_b = umx_reg;
            end
            DP_OFFY:
            begin
                mul_a = len_reg;
                mul_b = umy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // offset = round(len * |u| / 2^30) with the sign of u
    assign rnd     = prod_reg + (PW'(1) << (UFRAC - 1));
    assign off_mag = rnd[PW-1:UFRAC];
    assign off_neg = (cmd.op == DP_OFFY) ? sgx_reg : sgy_reg;
    assign off_c   = off_neg ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});

    assign newx = sat_coord(SUMW'(bx_reg) + SUMW'(offx_reg));
    assign newy = sat_coord(SUMW'(by_reg) + SUMW'(offy_reg));

    assign numx = (NUMW'(mx_reg) << UFRAC) + NUMW'(root >> 1);
    assign numy = (NUMW'(my_reg) << UFRAC) + NUMW'(root >> 1);

    fcs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.op == DP_ROOT_GO),
        .value (sum_reg),
        .done  (root_done),
        .root  (root)
    );

    fcs_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.op == DP_DIV_GO),
        .num   (numx),
        .den   (root),
        .done  (dvx_done),
        .quo   (quox)
    );

    fcs_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.op == DP_DIV_GO),
        .num   (numy),
        .den   (root),
        .done  (dvy_done),
        .quo   (quoy)
    );

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            arena_reg <= CFGW'(25600);
            cap_reg   <= CFGW'(2560);
            bad_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ARENA:   arena_reg <= cfg_data;
                    CFG_CAPTURE: cap_reg   <= cfg_data;
                endcase
            end
            valid_reg <= (cmd.op == DP_CLEAR) || (cmd.op == DP_APPEND) ||
                         (cmd.op == DP_EMIT_ZERO) || (cmd.op == DP_COMMIT_EMIT);
            unique case (cmd.op)
                DP_CLEAR:   count_reg <= '0;
                DP_APPEND:  count_reg <= count_reg + 1'b1;
                DP_BAD_CLR: bad_reg   <= 1'b0;
                DP_AR_CHK:  bad_reg   <= bad_reg | (sum_reg > ar2_reg);
                default:    ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD_IN:
            begin
                px_reg <= item.point_x;
                py_reg <= item.point_y;
            end
            DP_A_JOINT:
            begin
                bx_reg <= jx_rd;
                by_reg <= jy_rd;
            end
            DP_A_NEW:
            begin
                bx_reg <= nx_rd;
                by_reg <= ny_rd;
            end
            DP_B_JOINT, DP_B_NEW, DP_B_TGT, DP_AR_LD:
            begin
                mx_reg  <= ax_c;
                my_reg  <= ay_c;
                sgx_reg <= dx[COORD_BITS];
                sgy_reg <= dy[COORD_BITS];
            end
            DP_SQX:      prod_reg <= mul_p;
            DP_SQY:
            begin
                prod_reg <= mul_p;
                sum_reg  <= SQW'(prod_reg);
            end
            DP_SUM:      sum_reg <= sum_reg + SQW'(prod_reg);
            DP_ARENA_SQ: ar2_reg <= SQW'(mul_p);
            DP_UNIT:
            begin
                far_reg <= root > RW'(cap_reg);
                if (root == '0)
                begin
                    // zero length points along +x
                    umx_reg <= UW'(1) << UFRAC;
                    umy_reg <= '0;
                    sgx_reg <= 1'b0;
                    sgy_reg <= 1'b0;
                end
                else
                begin
                    umx_reg <= quox;
                    umy_reg <= quoy;
                end
            end
            DP_LEN_LOAD: len_reg <= len_rd;
            DP_LEN_CAP:  len_reg <= RW'(cap_reg);
            DP_OFFX:     prod_reg <= mul_p;
            DP_OFFY:
            begin
                prod_reg <= mul_p;
                offx_reg <= off_c;
            end
            DP_OFFEND:   offy_reg <= off_c;
            DP_TGT_FIX:
            begin
                if (far_reg)
                begin
                    px_reg <= newx;
                    py_reg <= newy;
                end
            end
            default:     ;
        endcase
    end

    // chain storage
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_APPEND:
            begin
                jx_mem[cmd.addr] <= px_reg;
                jy_mem[cmd.addr] <= py_reg;
            end
            DP_NEW_FROM_P:
            begin
                nx_mem[cmd.addr] <= px_reg;
                ny_mem[cmd.addr] <= py_reg;
            end
            DP_NEW_FROM_J:
            begin
                nx_mem[cmd.addr] <= jx_rd;
                ny_mem[cmd.addr] <= jy_rd;
            end
            DP_NEW_WRITE:
            begin
                nx_mem[cmd.addr] <= newx;
                ny_mem[cmd.addr] <= newy;
            end
            DP_COMMIT_EMIT:
            begin
                if (!bad_reg)
                begin
                    jx_mem[cmd.addr] <= nx_rd;
                    jy_mem[cmd.addr] <= ny_rd;
                end
            end
            DP_LEN_STORE: len_mem[cmd.addr] <= root;
            default:      ;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CLEAR, DP_EMIT_ZERO:
            begin
                res_reg.joint_index <= '0;
                res_reg.joint_x     <= '0;
                res_reg.joint_y     <= '0;
                res_reg.status      <= cmd.st;
                res_reg.last_of_run <= 1'b1;
            end
            DP_APPEND:
            begin
                res_reg.joint_index <= 4'(cmd.addr);
                res_reg.joint_x     <= 24'(px_reg);
                res_reg.joint_y     <= 24'(py_reg);
                res_reg.status      <= ST_OK;
                res_reg.last_of_run <= 1'b1;
            end
            DP_COMMIT_EMIT:
            begin
                res_reg.joint_index <= 4'(cmd.addr);
                res_reg.joint_x     <= bad_reg ? 24'(jx_rd) : 24'(nx_rd);
                res_reg.joint_y     <= bad_reg ? 24'(jy_rd) : 24'(ny_rd);
                res_reg.status      <= bad_reg ? ST_REJECT : ST_OK;
                res_reg.last_of_run <= cmd.last;
            end
            default: ;
        endcase
    end

    assign result_valid  = valid_reg;
    assign result        = res_reg;
    assign sts.count     = count_reg;
    assign sts.root_done = root_done;
    assign sts.div_done  = dvx_done & dvy_done;

    `FCS_ASSERT_SAME(a_count_max, 1'b1, count_reg <= CNTW'(MAX_JOINTS))
    `FCS_ASSERT_SAME(a_div_sync, 1'b1, dvx_done == dvy_done)
    `FCS_ASSERT_NEXT(a_reject_bad, cmd.op == DP_COMMIT_EMIT && bad_reg,
                     result_valid && result.status == ST_REJECT)

endmodule

// ----- rtl/core/fcs_ctrl.sv -----
// controller of the fabrik chain solver: sequences clear, append and the
// measure, offset, arena check and emit steps of a move; depends on fcs_pkg
`include "fabrik_chain_solver_core_assert.svh"
module fcs_ctrl import fcs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  opcode_t opcode,
    input  sts_t    sts,
    output logic    busy,
    output cmd_t    cmd
);

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [IDXW-1:0] i_reg, i_next;
    logic [IDXW-1:0] nm1;
    logic [IDXW-1:0] ip1, im1;
    logic            full;

    assign nm1  = IDXW'(sts.count - 1'b1);
    assign ip1  = i_reg + 1'b1;
    assign im1  = i_reg - 1'b1;
    assign full = sts.count >= CNTW'(MAX_JOINTS);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_APPEND: state_next = S_APPEND;
                        OP_MOVE:   state_next = (sts.count < CNTW'(2)) ? S_SHORT : S_ARSQ;
                        OP_NONE:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR, S_APPEND, S_SHORT: state_next = S_IDLE;
            S_ARSQ:
            begin
                state_next = S_T_A;
                phase_next = PH_TGT;
            end
            S_T_A:     state_next = S_T_B;
            S_T_B:     state_next = S_M_SQX;
            S_M_SQX:   state_next = S_M_SQY;
            S_M_SQY:   state_next = S_M_SUM;
            S_M_SUM:   state_next = (phase_reg == PH_ARENA) ? S_R_CHK : S_M_RGO;
            S_M_RGO:   state_next = S_M_RWAIT;
            S_M_RWAIT:
            begin
                if (sts.root_done)
                    state_next = (phase_reg == PH_LEN) ? S_L_ST : S_M_DGO;
            end
            S_M_DGO:   state_next = S_M_DWAIT;
            S_M_DWAIT:
            begin
                if (sts.div_done)
                    state_next = S_M_UNIT;
            end
            S_M_UNIT:
            begin
                priority if (phase_reg == PH_TGT)
                    state_next = S_T_LEN;
                else if (phase_reg == PH_BWD)
                    state_next = S_B_LEN;
                else
                    state_next = S_F_LEN;
            end
            S_T_LEN:   state_next = S_O_X;
            S_O_X:     state_next = S_O_Y;
            S_O_Y:     state_next = S_O_END;
            S_O_END:
            begin
                priority if (phase_reg == PH_TGT)
                    state_next = S_T_FIX;
                else if (phase_reg == PH_BWD)
                    state_next = S_B_WR;
                else
                    state_next = S_F_WR;
            end
            S_T_FIX:
            begin
                state_next = S_L_A;
                phase_next = PH_LEN;
                i_next     = '0;
            end
            S_L_A:     state_next = S_L_B;
            S_L_B:     state_next = S_M_SQX;
            S_L_ST:
            begin
                if (ip1 == nm1)
                    state_next = S_B_INIT;
                else
                begin
                    state_next = S_L_A;
                    i_next     = ip1;
                end
            end
            S_B_INIT:
            begin
                state_next = S_B_A;
                phase_next = PH_BWD;
                i_next     = nm1;
            end
            S_B_A:     state_next = S_B_B;
            S_B_B:     state_next = S_M_SQX;
            S_B_LEN:   state_next = S_O_X;
            S_B_WR:
            begin
                if (i_reg == IDXW'(1))
                    state_next = S_F_INIT;
                else
                begin
                    state_next = S_B_A;
                    i_next     = im1;
                end
            end
            S_F_INIT:
            begin
                state_next = S_F_A;
                phase_next = PH_FWD;
                i_next     = '0;
            end
            S_F_A:     state_next = S_F_B;
            S_F_B:     state_next = S_M_SQX;
            S_F_LEN:   state_next = S_O_X;
            S_F_WR:
            begin
                if (ip1 == nm1)
                    state_next = S_R_CLR;
                else
                begin
                    state_next = S_F_A;
                    i_next     = ip1;
                end
            end
            S_R_CLR:
            begin
                state_next = S_R_LD;
                phase_next = PH_ARENA;
                i_next     = '0;
            end
            S_R_LD:    state_next = S_M_SQX;
            S_R_CHK:
            begin
                if (i_reg == nm1)
                begin
                    state_next = S_EMIT;
                    i_next     = '0;
                end
                else
                begin
                    state_next = S_R_LD;
                    i_next     = ip1;
                end
            end
            S_EMIT:
            begin
                if (i_reg == nm1)
                    state_next = S_IDLE;
                else
                    i_next = ip1;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = DP_NOP;
        cmd.addr = i_reg;
        cmd.st   = ST_OK;
        cmd.last = 1'b0;
        unique case (state_reg)
            S_IDLE:    cmd.op = start ? DP_LOAD_IN : DP_NOP;
            S_CLEAR:   cmd.op = DP_CLEAR;
            S_APPEND:
            begin
                cmd.op   = full ? DP_EMIT_ZERO : DP_APPEND;
                cmd.addr = IDXW'(sts.count);
                cmd.st   = ST_FULL;
            end
            S_SHORT:
            begin
                cmd.op = DP_EMIT_ZERO;
                cmd.st = ST_SHORT;
            end
            S_ARSQ:    cmd.op = DP_ARENA_SQ;
            S_T_A:
            begin
                cmd.op   = DP_A_JOINT;
                cmd.addr = nm1;
            end
            S_T_B:     cmd.op = DP_B_TGT;
            S_M_SQX:   cmd.op = DP_SQX;
            S_M_SQY:   cmd.op = DP_SQY;
            S_M_SUM:   cmd.op = DP_SUM;
            S_M_RGO:   cmd.op = DP_ROOT_GO;
            S_M_DGO:   cmd.op = DP_DIV_GO;
            S_M_UNIT:  cmd.op = DP_UNIT;
            S_T_LEN:   cmd.op = DP_LEN_CAP;
            S_O_X:     cmd.op = DP_OFFX;
            S_O_Y:     cmd.op = DP_OFFY;
            S_O_END:   cmd.op = DP_OFFEND;
            S_T_FIX:   cmd.op = DP_TGT_FIX;
            S_L_A:     cmd.op = DP_A_JOINT;
            S_L_B:
            begin
                cmd.op   = DP_B_JOINT;
                cmd.addr = ip1;
            end
            S_L_ST:    cmd.op = DP_LEN_STORE;
            S_B_INIT:
            begin
                cmd.op   = DP_NEW_FROM_P;
                cmd.addr = nm1;
            end
            S_B_A:     cmd.op = DP_A_NEW;
            S_B_B:
            begin
                cmd.op   = DP_B_JOINT;
                cmd.addr = im1;
            end
            S_B_LEN:
            begin
                cmd.op   = DP_LEN_LOAD;
                cmd.addr = im1;
            end
            S_B_WR:
            begin
                cmd.op   = DP_NEW_WRITE;
                cmd.addr = im1;
            end
            S_F_INIT:
            begin
                cmd.op   = DP_NEW_FROM_J;
                cmd.addr = '0;
            end
            S_F_A:     cmd.op = DP_A_NEW;
            S_F_B:
            begin
                cmd.op   = DP_B_NEW;
                cmd.addr = ip1;
            end
            S_F_LEN:   cmd.op = DP_LEN_LOAD;
            S_F_WR:
            begin
                cmd.op   = DP_NEW_WRITE;
                cmd.addr = ip1;
            end
            S_R_CLR:   cmd.op = DP_BAD_CLR;
            S_R_LD:    cmd.op = DP_AR_LD;
            S_R_CHK:   cmd.op = DP_AR_CHK;
            S_EMIT:
            begin
                cmd.op   = DP_COMMIT_EMIT;
                cmd.last = (i_reg == nm1);
            end
            default:   cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_TGT;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `FCS_ASSERT_NEXT(a_accept_busy, state_reg == S_IDLE && start && opcode != OP_NONE,
                     state_reg != S_IDLE)
    `FCS_ASSERT_SAME(a_move_len, state_reg == S_L_A, sts.count >= CNTW'(2))
    `FCS_ASSERT_SAME(a_emit_range, state_reg == S_EMIT, i_reg <= nm1)

endmodule

// ----- rtl/core/fabrik_chain_solver_core.sv -----
// fabrik chain solver: clear and append hold busy for 1 cycle and strobe their result in the
// next cycle. a move on n joints holds busy through its passes: the root unit (26 steps) runs
// for the target and each link of the length, backward and forward passes, the two parallel
// dividers (31 steps) in all but the length pass; the n results come one per cycle, the last
// in the first cycle after busy falls, and cannot be stalled. reset: chain empty, arena_radius
// 25600, capture_radius 2560; joint storage is not cleared and busy is low right after reset.
module fabrik_chain_solver_core import fcs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  item_t           item,
    output logic            busy,
    output logic            result_valid,
    output result_t         result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  cfg_idx_t        cfg_index,
    input  logic [CFGW-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    fcs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
